[hdl/dff_pkg.sv]
// Package for the duplicate frame filter: default sizes, bus widths and the
// result record shared by the front, the result queue and the output stage.
// No dependencies.
package dff_pkg;

  // Default number of source entries in the lookup table.
  localparam int unsigned DEF_TABLE_ENTRIES = 16;

  // Field widths of one input item.
  localparam int unsigned SRC_W = 64;
  localparam int unsigned SEQ_W = 8;

  // Stream data widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 8;

  // Result queue between front and back; depth must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One result item, last field in the lowest bit.
  typedef struct packed {
    logic not_recorded;
    logic new_source;
    logic deliver;
  } dff_result_t;

endpackage

[hdl/dff_front.sv]
// Front of the duplicate frame filter: accepts items, compares them against
// the source table, updates the table and pushes one result per item.
// Depends on dff_pkg.
module dff_front import dff_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SRC_W-1:0] in_source_i,
  input  logic [SEQ_W-1:0] in_sequence_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output dff_result_t      push_result_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    FS_IDLE    = 2'b01,
    FS_RESOLVE = 2'b10
  } front_state_e;

  front_state_e state_q, state_d;

  logic [SEQ_W-1:0]         seq_q;
  logic [SRC_W-1:0]         in_source_hold_q;
  logic [TABLE_ENTRIES-1:0] match_q;
  logic [TABLE_ENTRIES-1:0] seq_eq_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [SRC_W-1:0]         source_q   [TABLE_ENTRIES];
  logic [SEQ_W-1:0]         sequence_q [TABLE_ENTRIES];
  logic [CNT_W-1:0]         used_q, used_d;

  logic take, commit, hit, dup, full, add;

  always_comb begin
    take   = in_valid_i && (state_q == FS_IDLE);
    hit    = |match_q;
    dup    = |(match_q & seq_eq_q);
    full   = (used_q == CNT_W'(TABLE_ENTRIES));
    add    = !hit && !full;
    commit = (state_q == FS_RESOLVE) && push_ready_i;

    in_ready_o                 = (state_q == FS_IDLE);
    push_valid_o               = (state_q == FS_RESOLVE);
    push_result_o.deliver      = !dup;
    push_result_o.new_source   = add;
    push_result_o.not_recorded = !hit && full;

    used_d  = used_q;
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: begin
        if (take) state_d = FS_RESOLVE;
      end
      FS_RESOLVE: begin
        if (commit) begin
          state_d = FS_IDLE;
          if (add) used_d = used_q + CNT_W'(1);
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) seq_q <= in_sequence_i;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
    logic wr_new;
    assign wr_new = commit && add && (used_q == CNT_W'(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (wr_new) begin
        valid_q[i] <= 1'b1;
      end
    end

    // Compare stage: one registered compare per entry.
    always_ff @(posedge clk_i) begin
      if (take) begin
        match_q[i]  <= valid_q[i] && (source_q[i] == in_source_i);
        seq_eq_q[i] <= (sequence_q[i] == in_sequence_i);
      end
    end

    // Table payload: written on a new source or a sequence update.
    always_ff @(posedge clk_i) begin
      if (wr_new) begin
        source_q[i]   <= in_source_hold_q;
        sequence_q[i] <= seq_q;
      end else if (commit && match_q[i]) begin
        sequence_q[i] <= seq_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) in_source_hold_q <= in_source_i;
  end

endmodule

[hdl/dff_queue.sv]
// Result queue of the duplicate frame filter: a short FIFO that decouples the
// table front from the output stage. Depends on dff_pkg.
module dff_queue import dff_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  dff_result_t push_data_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output dff_result_t pop_data_o
);

  dff_result_t       slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  always_comb begin
    push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
    pop_valid_o  = (count_q != '0);
    pop_data_o   = slot_q[rd_ptr_q];
    push         = push_valid_i && push_ready_o;
    pop          = pop_valid_o && pop_ready_i;
    count_d      = count_q;
    if (push && !pop) count_d = count_q + QCNT_W'(1);
    if (pop && !push) count_d = count_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[hdl/dff_back.sv]
// Output stage of the duplicate frame filter: registers one result item and
// presents it on the master stream. Depends on dff_pkg.
module dff_back import dff_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  dff_result_t            pop_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  logic        valid_q;
  dff_result_t data_q;

  assign pop_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = {{(OUT_TDATA_W - $bits(dff_result_t)){1'b0}}, data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) data_q <= pop_data_i;
  end

endmodule

[hdl/duplicate_frame_filter.sv]
// Duplicate frame filter. An item is accepted only once the table compare
// and the table update of the previous item, done in turn, are complete.
// Its result goes to m_axis through a two-entry result queue and an output
// register, which absorb stalls.
// Reset clears every valid mark and the fill count at once, with no sweep;
// the block accepts items from the first cycle after reset.
// Depends on dff_pkg, dff_front, dff_queue and dff_back.
module duplicate_frame_filter import dff_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [63:0] source_address, [71:64] sequence_number
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] deliver, [1] new_source, [2] not_recorded, [7:3] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Front to queue.
  logic        push_valid, push_ready;
  dff_result_t push_result;

  // Queue to output stage.
  logic        pop_valid, pop_ready;
  dff_result_t pop_data;

  // Classify against the table and update it; hold the item while the queue
  // is full.
  dff_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_source_i  (s_axis_tdata[SRC_W-1:0]),
    .in_sequence_i(s_axis_tdata[SRC_W+SEQ_W-1:SRC_W]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_result_o(push_result)
  );

  // Buffer results so the front keeps going while the sink stalls.
  dff_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_result),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // Drive the master stream from a register.
  dff_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule
